@@ hdl/kffc_pkg.sv @@
// package for the keypad calculator: key codes, event kinds, operator and state types
package kffc_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;

    localparam logic [7:0] KEY_CLEAR  = 8'h52;
    localparam logic [7:0] KEY_NONE   = 8'hff;
    localparam logic [7:0] KEY_ZERO   = 8'h30;
    localparam logic [7:0] KEY_NINE   = 8'h39;
    localparam logic [7:0] KEY_PLUS   = 8'h2b;
    localparam logic [7:0] KEY_MINUS  = 8'h2d;
    localparam logic [7:0] KEY_TIMES  = 8'h2a;
    localparam logic [7:0] KEY_DIVIDE = 8'h2f;
    localparam logic [7:0] KEY_EQUALS = 8'h3d;

    localparam logic [2:0] KIND_DIGIT    = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_RESULT   = 3'd2;
    localparam logic [2:0] KIND_DIV_ZERO = 3'd3;
    localparam logic [2:0] KIND_CLEARED  = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV_NA,
        S_DIV_NB,
        S_DIV,
        S_DIV_NQ,
        S_FIN
    } t_state;

endpackage

@@ hdl/kffc_if.sv @@
// valid/ready channel interfaces for key and event transactions
interface kffc_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface kffc_event_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  event_kind;
    logic signed [31:0] event_value;

    modport source (output valid, output event_kind, output event_value, input ready);
    modport sink   (input valid, input event_kind, input event_value, output ready);
endinterface

@@ hdl/keypad_four_function_calculator_core.sv @@
// keypad calculator core: key decode, operand entry and shared iterative arithmetic unit
// key, operator and add/subtract events pass S_EXEC and S_FIN into the output register; S_FIN stalls
// while it is full; multiply runs the one-bit-a-cycle shift-add loop in S_MUL and divide the
// restoring-divide loop in S_DIV, both on the shared adder; one key at a time
// a new key is taken while a finished event waits in the output register
// synchronous active-low reset clears operands, operator, phase and all handshake state
module keypad_four_function_calculator_core #(
    parameter int OPERAND_WIDTH = kffc_pkg::OPERAND_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kffc_key_if.sink      i_key,
    kffc_event_if.source  o_evt
);
    import kffc_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int AW = OPERAND_WIDTH + 2;
    localparam int CW = $clog2(OPERAND_WIDTH);

    t_state          r_state, n_state;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    t_op             r_op, n_op;
    logic            r_phase, n_phase;
    logic [7:0]      r_key, n_key;
    logic [W-1:0]    r_acc, n_acc;
    logic [W-1:0]    r_wa, n_wa;
    logic [W-1:0]    r_wb, n_wb;
    logic            r_neg, n_neg;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [2:0]      r_res_kind, n_res_kind;
    logic [31:0]     r_res_val, n_res_val;
    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_out_kind, n_out_kind;
    logic [31:0]     r_out_val, n_out_val;

    logic [AW-1:0]   u_x, u_y, u_sum;
    logic            u_sub;
    logic            slot_free;
    logic            cnt_last;
    logic [W-1:0]    digit_a, digit_b;
    logic [W-1:0]    digit_val;

    // shared adder/subtractor
    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                u_x   = {2'b00, r_a};
                u_y   = {2'b00, r_b};
                u_sub = (r_op == OP_SUB);
            end
            S_MUL: begin
                u_x = {2'b00, r_acc};
                u_y = {2'b00, r_wa};
            end
            S_DIV_NA: begin
                u_y   = {2'b00, r_a};
                u_sub = 1'b1;
            end
            S_DIV_NB: begin
                u_y   = {2'b00, r_b};
                u_sub = 1'b1;
            end
            S_DIV: begin
                u_x   = {1'b0, r_acc, r_wa[W-1]};
                u_y   = {2'b00, r_wb};
                u_sub = 1'b1;
            end
            S_DIV_NQ: begin
                u_y   = {2'b00, r_wa};
                u_sub = 1'b1;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
    end

    assign u_sum = u_x + (u_sub ? ~u_y : u_y) + AW'(u_sub);

    assign slot_free = !r_out_valid || o_evt.ready;
    assign cnt_last  = (r_cnt == CW'(W - 1));
    assign digit_val = W'(r_key - KEY_ZERO);
    assign digit_a   = {r_a[W-4:0], 3'b000} + {r_a[W-2:0], 1'b0} + digit_val;
    assign digit_b   = {r_b[W-4:0], 3'b000} + {r_b[W-2:0], 1'b0} + digit_val;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_op        = r_op;
        n_phase     = r_phase;
        n_key       = r_key;
        n_acc       = r_acc;
        n_wa        = r_wa;
        n_wb        = r_wb;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_res_kind  = r_res_kind;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_key.valid) begin
                    n_key   = i_key.key_code;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_key) inside
                    KEY_CLEAR: begin
                        n_a        = '0;
                        n_b        = '0;
                        n_op       = OP_ADD;
                        n_phase    = 1'b0;
                        n_res_kind = KIND_CLEARED;
                        n_res_val  = '0;
                        n_state    = S_FIN;
                    end
                    [KEY_ZERO:KEY_NINE]: begin
                        if (r_phase) begin
                            n_b = digit_b;
                        end else begin
                            n_a = digit_a;
                        end
                        n_res_kind = KIND_DIGIT;
                        n_res_val  = {24'd0, r_key};
                        n_state    = S_FIN;
                    end
                    KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_DIVIDE: begin
                        if (!r_phase) begin
                            unique case (r_key)
                                KEY_PLUS:  n_op = OP_ADD;
                                KEY_MINUS: n_op = OP_SUB;
                                KEY_TIMES: n_op = OP_MUL;
                                default:   n_op = OP_DIV;
                            endcase
                            n_phase    = 1'b1;
                            n_res_kind = KIND_OPERATOR;
                            n_res_val  = {24'd0, r_key};
                            n_state    = S_FIN;
                        end
                    end
                    KEY_EQUALS: begin
                        if (r_phase) begin
                            n_res_kind = KIND_RESULT;
                            unique case (r_op)
                                OP_ADD, OP_SUB: begin
                                    n_res_val = 32'($signed(u_sum[W-1:0]));
                                    n_state   = S_FIN;
                                end
                                OP_MUL: begin
                                    n_acc   = '0;
                                    n_wa    = r_a;
                                    n_wb    = r_b;
                                    n_cnt   = '0;
                                    n_state = S_MUL;
                                end
                                default: begin
                                    if (r_b == '0) begin
                                        n_a        = '0;
                                        n_b        = '0;
                                        n_op       = OP_ADD;
                                        n_phase    = 1'b0;
                                        n_res_kind = KIND_DIV_ZERO;
                                        n_res_val  = '0;
                                        n_state    = S_FIN;
                                    end else begin
                                        n_neg   = r_a[W-1] ^ r_b[W-1];
                                        n_state = S_DIV_NA;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                if (r_wb[0]) begin
                    n_acc = u_sum[W-1:0];
                end
                n_wa  = {r_wa[W-2:0], 1'b0};
                n_wb  = {1'b0, r_wb[W-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = S_FIN;
                end
            end
            S_DIV_NA: begin
                n_wa    = r_a[W-1] ? u_sum[W-1:0] : r_a;
                n_state = S_DIV_NB;
            end
            S_DIV_NB: begin
                n_wb    = r_b[W-1] ? u_sum[W-1:0] : r_b;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!u_sum[AW-1]) begin
                    n_acc = u_sum[W-1:0];
                end else begin
                    n_acc = {r_acc[W-2:0], r_wa[W-1]};
                end
                n_wa  = {r_wa[W-2:0], ~u_sum[AW-1]};
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = S_DIV_NQ;
                end
            end
            S_DIV_NQ: begin
                n_acc   = r_neg ? u_sum[W-1:0] : r_wa;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    if (r_res_kind == KIND_RESULT && r_op inside {OP_MUL, OP_DIV}) begin
                        n_out_val = 32'($signed(r_acc));
                    end else begin
                        n_out_val = r_res_val;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a         <= '0;
            r_b         <= '0;
            r_op        <= OP_ADD;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_b         <= n_b;
            r_op        <= n_op;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_acc      <= n_acc;
        r_wa       <= n_wa;
        r_wb       <= n_wb;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_res_kind <= n_res_kind;
        r_res_val  <= n_res_val;
        r_out_kind <= n_out_kind;
        r_out_val  <= n_out_val;
    end

    assign i_key.ready       = (r_state == S_IDLE);
    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_out_kind;
    assign o_evt.event_value = $signed(r_out_val);

endmodule
